/* rtl/core/fuzzy_subsequence_scorer_macros.svh */
// Assertion shorthands for the fuzzy subsequence scorer.
// Each one is clocked on aclk and is disabled while aresetn is low.
`ifndef FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fss assertion failed");

// Next-cycle implication
`define FSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fss assertion failed");

`else

`define FSS_ASSERT_NOW(label, ante, cons)
`define FSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/fss_pkg.sv */
`default_nettype none

package fss_pkg;

    // Query geometry
    localparam int QUERY_MAX  = 16;
    localparam int QIDX_W     = $clog2(QUERY_MAX);
    localparam int QLEN_W     = 5;
    localparam int BYTE_W     = 8;

    // Result geometry
    localparam int STREAK_W   = 5;
    localparam int SCORE_W    = 8;
    localparam int OUT_W      = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LEN  = 2'd2;

    // Characters
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET    = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_DASH      = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_UNDERLINE = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_DOT       = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_COLON     = 8'h3A;

    // Scoring
    localparam logic [SCORE_W-1:0] SEP_BONUS     = 8'd4;
    localparam logic [SCORE_W-1:0] HIT_BASE      = 8'd1;
    localparam logic [OUT_W-1:0]   NO_MATCH      = 9'h1FF;

    typedef logic [QUERY_MAX-1:0][BYTE_W-1:0] query_t;

    // One name beat as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] name_byte;
        logic              byte_present;
        logic              name_end;
    } item_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_separator(input logic [BYTE_W-1:0] c);
        return (c == CHAR_SLASH) || (c == CHAR_DASH) || (c == CHAR_UNDERLINE) ||
               (c == CHAR_DOT) || (c == CHAR_COLON);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fuzzy_subsequence_scorer.sv */
// Fuzzy subsequence scorer.
// Load the query with the write port: index 0 takes query bytes 0..7, index 1
// bytes 8..15, index 2 the query length from its low 5 bits (values above 16
// act as 16). Write only while no name is in flight.
// Stream each candidate name on the s_axis channel, one byte per beat; tlast
// marks the last beat of a name and tuser flags whether tdata carries a byte
// (an empty name is one beat with tlast high and tuser low).
// The m_axis channel returns one beat per name: the 9-bit signed score, or -1
// if the query was not matched in full.
// The last name beat passes through the input register and then the output
// register before its score shows on m_axis. Throughput is one beat per cycle
// barring the stall below; the match state updates from the input register.
// Reset clears the query, the match state and both pipeline valid flags.
// When the receiver stalls, the score stays in the output register; byte beats
// still flow, and the input stops only when a second name end arrives while
// the previous score has not been taken.
`default_nettype none

`include "fuzzy_subsequence_scorer_macros.svh"

module fuzzy_subsequence_scorer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration
    input  wire logic                           cfg_we,
    input  wire logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Name bytes in
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] name_byte
    input  wire logic                           s_axis_tuser,  // [0] byte_present
    input  wire logic                           s_axis_tlast,  // name_end
    // Scores out
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [15:0]                         m_axis_tdata   // [8:0] match_score
);
    import fss_pkg::*;

    query_t            query;
    logic [QLEN_W-1:0] query_len;

    logic              in_valid_reg;
    item_t             in_item_reg;
    logic              out_free;
    logic              advance;
    logic [OUT_W-1:0]  score_out;
    logic              end_waiting;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_score_reg;

    fss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .query     (query),
        .query_len (query_len)
    );

    // A beat moves on unless it ends a name and the output slot is full and not being taken
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_item_reg.name_end || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.name_byte    <= s_axis_tdata;
            in_item_reg.byte_present <= s_axis_tuser;
            in_item_reg.name_end     <= s_axis_tlast;
        end
    end

    fss_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .query     (query),
        .query_len (query_len),
        .score_out (score_out)
    );

    // Output register: load on a name end, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.name_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.name_end) begin
            m_score_reg <= score_out;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_score_reg};

    // A name end sits in the input register
    assign end_waiting = in_valid_reg && in_item_reg.name_end;

    // A name end that moves on always leaves a score in the output register
    `FSS_ASSERT_NEXT(a_score_after_end, advance && in_item_reg.name_end, m_valid_reg)

    // A name end facing a stalled, full output must block the input side
    `FSS_ASSERT_NOW(a_block_on_full, end_waiting && m_valid_reg && !m_axis_tready, !s_axis_tready)

    // A blocked name end stays in the input register
    `FSS_ASSERT_NEXT(a_hold_blocked_end, in_valid_reg && !advance, end_waiting)

endmodule

`default_nettype wire

/* rtl/core/fss_cfg_regs.sv */
`default_nettype none

module fss_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [fss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fss_pkg::query_t                      query,
    output logic [fss_pkg::QLEN_W-1:0]           query_len
);
    import fss_pkg::*;

    logic [CFG_DATA_W-1:0] query_low_reg;
    logic [CFG_DATA_W-1:0] query_high_reg;
    logic [QLEN_W-1:0]     query_len_reg;

    // Write the addressed register; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_low_reg  <= '0;
            query_high_reg <= '0;
            query_len_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_QUERY_LOW:  query_low_reg  <= cfg_wdata;
                REG_QUERY_HIGH: query_high_reg <= cfg_wdata;
                REG_QUERY_LEN:  query_len_reg  <= cfg_wdata[QLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Byte 0 sits in the low bits of the low word
    assign query = {query_high_reg, query_low_reg};

    // Clamp the length to the query capacity
    assign query_len = (query_len_reg > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX)
                                                             : query_len_reg;

endmodule

`default_nettype wire

/* rtl/core/fss_match.sv */
`default_nettype none

module fss_match (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step,
    input  fss_pkg::item_t                    item,
    input  fss_pkg::query_t                   query,
    input  wire logic [fss_pkg::QLEN_W-1:0]   query_len,
    output logic [fss_pkg::OUT_W-1:0]         score_out
);
    import fss_pkg::*;

    logic [QLEN_W-1:0]   pos_reg,      pos_next;
    logic [STREAK_W-1:0] streak_reg,   streak_next;
    logic [SCORE_W-1:0]  score_reg,    score_next;
    logic                prev_sep_reg, prev_sep_next;

    logic [BYTE_W-1:0]   query_char;
    logic [BYTE_W-1:0]   name_char;
    logic                active;
    logic                hit;
    logic [STREAK_W-1:0] streak_inc;
    logic [SCORE_W-1:0]  gain;

    // Compare against the next unmatched query byte
    assign active     = item.byte_present && (pos_reg < query_len);
    assign query_char = fold_case(query[pos_reg[QIDX_W-1:0]]);
    assign name_char  = fold_case(item.name_byte);
    assign hit        = active && (query_char == name_char);

    assign streak_inc = streak_reg + STREAK_W'(1);
    assign gain       = SCORE_W'(streak_inc) + HIT_BASE + (prev_sep_reg ? SEP_BONUS : '0);

    // Advance position, streak and score for this beat
    always_comb begin
        pos_next      = pos_reg;
        streak_next   = streak_reg;
        score_next    = score_reg;
        prev_sep_next = prev_sep_reg;
        if (hit) begin
            pos_next    = pos_reg + QLEN_W'(1);
            streak_next = streak_inc;
            score_next  = score_reg + gain;
        end else if (active) begin
            streak_next = '0;
        end
        if (active) begin
            prev_sep_next = is_separator(item.name_byte);
        end
    end

    // Final score for a name-end beat
    assign score_out = (pos_next >= query_len) ? {1'b0, score_next} : NO_MATCH;

    // Hold state between beats; clear after the last beat of a name
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            streak_reg   <= '0;
            score_reg    <= '0;
            prev_sep_reg <= 1'b1;
        end else if (step) begin
            if (item.name_end) begin
                pos_reg      <= '0;
                streak_reg   <= '0;
                score_reg    <= '0;
                prev_sep_reg <= 1'b1;
            end else begin
                pos_reg      <= pos_next;
                streak_reg   <= streak_next;
                score_reg    <= score_next;
                prev_sep_reg <= prev_sep_next;
            end
        end
    end

endmodule

`default_nettype wire

/* verif/tb_fuzzy_subsequence_scorer.sv */
module tb_fuzzy_subsequence_scorer;
    timeunit 1ns;
    timeprecision 1ps;

    import fss_pkg::*;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tready = 1'b1;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [15:0]           m_axis_tdata;

    // Golden copy of the query registers and the per-name match state
    logic [63:0] gold_qlow     = '0;
    logic [63:0] gold_qhigh    = '0;
    logic [4:0]  gold_qlen     = '0;
    logic [4:0]  gold_pos      = '0;
    logic [4:0]  gold_streak   = '0;
    logic [7:0]  gold_score    = '0;
    logic        gold_prev_sep = 1'b1;

    logic [8:0] pending_scores[$];
    logic [8:0] score_due;
    bit         idle_on         = 1'b1;
    int         mismatch_count  = 0;
    int         names_scored    = 0;
    int         beats_sent      = 0;
    int         counted_beats   = 0;
    int         settings_loaded = 0;

    fuzzy_subsequence_scorer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? (c | 8'h20) : c;
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return c == CHAR_SLASH || c == CHAR_DASH || c == CHAR_UNDERLINE ||
               c == CHAR_DOT || c == CHAR_COLON;
    endfunction

    // Advance the golden match state by one accepted name beat
    function automatic void score_name_beat(input logic [7:0] b, input logic present,
                                            input logic last);
        logic [4:0]   len;
        logic [127:0] qwords;
        logic [7:0]   qc;
        len = (gold_qlen > 5'd16) ? 5'd16 : gold_qlen;
        qwords = {gold_qhigh, gold_qlow};
        if (present && gold_pos < len) begin
            qc = qwords[gold_pos[3:0]*8 +: 8];
            if (lower_ascii(b) == lower_ascii(qc)) begin
                gold_streak = gold_streak + 5'd1;
                gold_score = gold_score + 8'd1 + {3'b000, gold_streak} +
                             (gold_prev_sep ? 8'd4 : 8'd0);
                gold_pos = gold_pos + 5'd1;
            end else begin
                gold_streak = '0;
            end
            gold_prev_sep = is_sep(b);
        end
        if (last) begin
            pending_scores.push_back((gold_pos >= len) ? {1'b0, gold_score} : NO_MATCH);
            gold_pos = '0;
            gold_streak = '0;
            gold_score = '0;
            gold_prev_sep = 1'b1;
            names_scored++;
        end
    endfunction

    // Mix of letters in both cases, separators, current query bytes and raw bytes
    function automatic logic [7:0] random_text_byte();
        logic [127:0] qwords;
        int pick;
        qwords = {gold_qhigh, gold_qlow};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return 8'h41 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end else if (pick < 60) begin
            case ($urandom_range(0, 4))
                0: return CHAR_SLASH;
                1: return CHAR_DASH;
                2: return CHAR_UNDERLINE;
                3: return CHAR_DOT;
                default: return CHAR_COLON;
            endcase
        end else if (pick < 80) begin
            return qwords[$urandom_range(0, 15)*8 +: 8];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, $signed(got), $signed(want));
        mismatch_count++;
    endtask

    // Send one name beat; tvalid stays high afterwards unless a gap follows
    task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
        if (idle_on && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        score_name_beat(b, present, last);
        beats_sent++;
        if (present || last) begin
            counted_beats++;
        end
    endtask

    // Drop valid, drain all scores, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_QUERY_LOW:  gold_qlow = value;
            REG_QUERY_HIGH: gold_qhigh = value;
            REG_QUERY_LEN:  gold_qlen = value[4:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_query(input logic [127:0] q, input logic [63:0] len_word);
        settle();
        write_reg(REG_QUERY_LOW, q[63:0]);
        write_reg(REG_QUERY_HIGH, q[127:64]);
        write_reg(REG_QUERY_LEN, len_word);
        settings_loaded++;
    endtask

    // Random name: mostly the query spread out with noise, sometimes pure noise
    task automatic send_random_name();
        logic [7:0]   text[$];
        logic [127:0] qwords;
        logic [7:0]   c;
        int           len;
        bit           end_bare;
        qwords = {gold_qhigh, gold_qlow};
        len = (gold_qlen > 5'd16) ? 16 : int'(gold_qlen);
        if ($urandom_range(0, 99) < 70) begin
            for (int i = 0; i < len; i++) begin
                repeat ($urandom_range(0, 2)) text.push_back(random_text_byte());
                if ($urandom_range(0, 99) >= 8) begin
                    c = qwords[i*8 +: 8];
                    if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1))
                        c = c ^ 8'h20;
                    text.push_back(c);
                end
            end
            repeat ($urandom_range(0, 2)) text.push_back(random_text_byte());
        end else begin
            repeat ($urandom_range(0, 6)) text.push_back(random_text_byte());
        end
        end_bare = (text.size() == 0) || ($urandom_range(0, 99) < 25);
        foreach (text[i]) begin
            if ($urandom_range(0, 99) < 4)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(text[i], 1'b1, !end_bare && (i == text.size() - 1));
        end
        if (end_bare)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Reset state: empty query scores zero, byteless beats do nothing
    task automatic test_empty_query();
        send_beat(8'h51, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // Case folding at the letter range edges, separator bonus, zero byte in query
    task automatic test_fold_and_separators();
        load_query({{32'($urandom), 32'($urandom)}, 64'h00000000_00407A61}, 64'd4);
        send_beat(8'h41, 1'b1, 1'b0);
        send_beat(CHAR_COLON, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b1, 1'b0);
        send_beat(8'h60, 1'b1, 1'b0);
        send_beat(8'h40, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
    endtask

    // Oversized length acts as 16; all-slash query reaches the top score
    task automatic test_full_query();
        load_query({16{CHAR_SLASH}}, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 17; i++)
            send_beat(CHAR_SLASH, 1'b1, i == 16);
    endtask

    // Shorten the query between beats of one name
    task automatic test_query_change_midname();
        load_query({64'd0, 64'h00000000_64636261}, 64'd4);
        send_beat(8'h61, 1'b1, 1'b0);
        settle();
        write_reg(REG_QUERY_LEN, 64'd1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_queries();
        logic [127:0] q;
        logic [63:0]  len_word;
        int           beats_start;
        int           names_start;
        for (int phase = 0; phase < 10; phase++) begin
            for (int i = 0; i < 16; i++)
                q[i*8 +: 8] = random_text_byte();
            case (phase)
                0: len_word = 64'd1;
                1: begin
                    q = '1;
                    len_word = 64'd16;
                end
                2: len_word = {32'($urandom), 32'($urandom)} | 64'h1F;
                3: len_word = {32'($urandom), 32'($urandom)} & ~64'h1F;
                4: begin
                    q = '0;
                    len_word = 64'($urandom_range(1, 8));
                end
                default: len_word = $urandom_range(0, 1) ? 64'($urandom_range(1, 6))
                                                         : 64'($urandom_range(0, 31));
            endcase
            load_query(q, len_word);
            idle_on = (phase != 6);
            beats_start = counted_beats;
            names_start = names_scored;
            do send_random_name();
            while (counted_beats - beats_start < 40 || names_scored - names_start < 3);
        end
        idle_on = 1'b1;
    endtask

    // Check each score beat against the oldest prediction; stall at random
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_scores.size() == 0) begin
                report_mismatch("score beat with no name pending", m_axis_tdata[8:0], 9'd0);
            end else begin
                score_due = pending_scores.pop_front();
                if (m_axis_tdata[8:0] !== score_due)
                    report_mismatch("match_score", m_axis_tdata[8:0], score_due);
            end
        end
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 11);
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_query();
        test_fold_and_separators();
        test_full_query();
        test_query_change_midname();
        test_random_queries();
        settle();
        $display("Scored %0d names from %0d name beats under %0d query settings,",
                 names_scored, beats_sent, settings_loaded);
        $display("including empty, oversized and mid-name query changes.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #2_000_000;
        $display("Timeout with %0d scores outstanding", pending_scores.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
